[src/smm_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// Semiring matrix multiply package
// Shared widths, codes, interface structs and saturation helpers.
// ----------------------------------------------------------------------------
package smm_pkg;

  localparam int SMM_MAX_DIM    = 8;
  localparam int SMM_FIFO_DEPTH = 2;

  localparam int DIM_W   = 4;   // width of a dimension register
  localparam int IDX_W   = 3;   // width of a row or column index field
  localparam int VAL_W   = 32;  // width of a matrix entry
  localparam int PROD_W  = 2 * VAL_W;
  localparam int ACC_W   = PROD_W + 4;  // room for eight finite products
  localparam int TDATA_W = 40;

  localparam logic [VAL_W-1:0] POS_INF = 32'h7FFF_FFFF;
  localparam logic [VAL_W-1:0] NEG_INF = 32'h8000_0000;
  localparam logic [VAL_W-1:0] FIN_MAX = 32'h7FFF_FFFE;
  localparam logic [VAL_W-1:0] FIN_MIN = 32'h8000_0001;

  typedef enum logic [1:0] {
    CMD_WR_A = 2'd0,
    CMD_WR_B = 2'd1,
    CMD_RUN  = 2'd2
  } cmd_e;

  typedef enum logic [1:0] {
    MODE_SOP = 2'd0,
    MODE_MIN = 2'd1,
    MODE_MAX = 2'd2
  } mode_e;

  typedef enum logic [1:0] {
    REG_MODE  = 2'd0,
    REG_ROWS  = 2'd1,
    REG_INNER = 2'd2,
    REG_COLS  = 2'd3
  } reg_e;

  typedef enum logic {
    SEQ_IDLE,
    SEQ_RUN
  } seq_e;

  typedef struct packed {
    cmd_e             op;
    logic [IDX_W-1:0] row;
    logic [IDX_W-1:0] col;
    logic [VAL_W-1:0] value;
  } smm_cmd_t;

  typedef struct packed {
    logic [1:0]       mode;
    logic [DIM_W-1:0] rows;
    logic [DIM_W-1:0] inner;
    logic [DIM_W-1:0] cols;
  } smm_cfg_t;

  // Saturate a 33-bit signed sum to the finite range.
  function automatic logic [VAL_W-1:0] sat_sum(input logic [VAL_W:0] s);
    logic signed [VAL_W:0] sv;
    logic signed [VAL_W:0] hi;
    logic signed [VAL_W:0] lo;
    sv = $signed(s);
    hi = $signed({1'b0, FIN_MAX});
    lo = $signed({1'b1, FIN_MIN});
    if (sv > hi) begin
      return FIN_MAX;
    end else if (sv < lo) begin
      return FIN_MIN;
    end else begin
      return s[VAL_W-1:0];
    end
  endfunction

  // Saturate the wide product accumulator to the finite range.
  function automatic logic [VAL_W-1:0] sat_acc(input logic [ACC_W-1:0] a);
    logic signed [ACC_W-1:0] av;
    logic signed [ACC_W-1:0] hi;
    logic signed [ACC_W-1:0] lo;
    av = $signed(a);
    hi = $signed({{(ACC_W-VAL_W){1'b0}}, FIN_MAX});
    lo = $signed({{(ACC_W-VAL_W){1'b1}}, FIN_MIN});
    if (av > hi) begin
      return FIN_MAX;
    end else if (av < lo) begin
      return FIN_MIN;
    end else begin
      return a[VAL_W-1:0];
    end
  endfunction

endpackage
`default_nettype wire

[src/semiring_matrix_multiply.sv]
`default_nettype none
// Load beats are accepted one per cycle while the front register is free or the queue
// has room; the front register and the two-entry command queue take up to three beats
// while the back end is busy with a product. A compute beat holds the back end for the
// whole product, one A/B read pair a cycle while the output is not stalled, and yields
// one result per output entry once its inner terms are accumulated.
// Reset: asynchronous, active low; control and configuration reset, A and B stores do not.
// ----------------------------------------------------------------------------
// Semiring matrix multiply
// Loads A and B entry by entry and streams their product in sum-of-products,
// min-plus or max-plus arithmetic, row by row, with tlast on the final entry.
// ----------------------------------------------------------------------------
module semiring_matrix_multiply import smm_pkg::*; #(
  parameter int MAX_DIM    = SMM_MAX_DIM,
  parameter int FIFO_DEPTH = SMM_FIFO_DEPTH
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  // APB configuration port
  input  wire logic               psel,
  input  wire logic               penable,
  input  wire logic               pwrite,
  input  wire logic [3:0]         paddr,
  input  wire logic [31:0]        pwdata,
  output logic      [31:0]        prdata,
  output logic                    pready,
  // input stream
  input  wire logic               s_axis_tvalid,
  output logic                    s_axis_tready,
  input  wire logic [TDATA_W-1:0] s_axis_tdata,  // row_index[2:0], col_index[5:3],
                                                  // entry_value[37:6], zero[39:38]
  input  wire logic [1:0]         s_axis_tuser,  // cmd[1:0]
  // output stream
  output logic                    m_axis_tvalid,
  input  wire logic               m_axis_tready,
  output logic      [TDATA_W-1:0] m_axis_tdata,  // out_row[2:0], out_col[5:3],
                                                  // out_value[37:6], zero[39:38]
  output logic                    m_axis_tlast
);

  // --------------------------------------------------------------------------
  // Configuration registers
  // --------------------------------------------------------------------------
  smm_cfg_t cfg_q;
  logic     cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.mode  <= MODE_SOP;
      cfg_q.rows  <= DIM_W'(8);
      cfg_q.inner <= DIM_W'(8);
      cfg_q.cols  <= DIM_W'(8);
    end else if (cfg_wr) begin
      case (reg_e'(paddr[3:2]))
        REG_MODE:  cfg_q.mode  <= pwdata[1:0];
        REG_ROWS:  cfg_q.rows  <= pwdata[DIM_W-1:0];
        REG_INNER: cfg_q.inner <= pwdata[DIM_W-1:0];
        REG_COLS:  cfg_q.cols  <= pwdata[DIM_W-1:0];
        default:   cfg_q.mode  <= cfg_q.mode;
      endcase
    end
  end

  always_comb begin
    case (reg_e'(paddr[3:2]))
      REG_MODE:  prdata = {30'd0, cfg_q.mode};
      REG_ROWS:  prdata = {{(32-DIM_W){1'b0}}, cfg_q.rows};
      REG_INNER: prdata = {{(32-DIM_W){1'b0}}, cfg_q.inner};
      REG_COLS:  prdata = {{(32-DIM_W){1'b0}}, cfg_q.cols};
      default:   prdata = '0;
    endcase
  end

  // --------------------------------------------------------------------------
  // Front, queue, back
  // --------------------------------------------------------------------------
  logic     push, full, q_valid, q_pop;
  smm_cmd_t front_cmd, q_cmd;

  smm_front #(
    .MAX_DIM (MAX_DIM)
  ) u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (s_axis_tvalid),
    .ready_o (s_axis_tready),
    .cmd_i   (s_axis_tuser),
    .row_i   (s_axis_tdata[2:0]),
    .col_i   (s_axis_tdata[5:3]),
    .value_i (s_axis_tdata[37:6]),
    .push_o  (push),
    .cmd_o   (front_cmd),
    .full_i  (full)
  );

  smm_fifo #(
    .DEPTH (FIFO_DEPTH)
  ) u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .wdata_i (front_cmd),
    .full_o  (full),
    .valid_o (q_valid),
    .rdata_o (q_cmd),
    .pop_i   (q_pop)
  );

  logic [IDX_W-1:0] out_row, out_col;
  logic [VAL_W-1:0] out_value;

  smm_back #(
    .MAX_DIM (MAX_DIM)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .q_valid_i   (q_valid),
    .q_cmd_i     (q_cmd),
    .q_pop_o     (q_pop),
    .m_valid_o   (m_axis_tvalid),
    .m_ready_i   (m_axis_tready),
    .out_row_o   (out_row),
    .out_col_o   (out_col),
    .out_value_o (out_value),
    .out_last_o  (m_axis_tlast)
  );

  assign m_axis_tdata = {2'b00, out_value, out_col, out_row};

endmodule
`default_nettype wire

[src/smm_ram.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// Generic RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module smm_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule
`default_nettype wire

[src/smm_front.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// Front end
// Accepts input beats, drops unused commands and out-of-range writes, and
// hands the kept commands to the command queue.
// ----------------------------------------------------------------------------
module smm_front import smm_pkg::*; #(
  parameter int MAX_DIM = SMM_MAX_DIM
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             valid_i,
  output logic                  ready_o,
  input  wire logic [1:0]       cmd_i,
  input  wire logic [IDX_W-1:0] row_i,
  input  wire logic [IDX_W-1:0] col_i,
  input  wire logic [VAL_W-1:0] value_i,
  output logic                  push_o,
  output smm_cmd_t              cmd_o,
  input  wire logic             full_i
);

  logic     vld_q;
  smm_cmd_t cmd_q;
  logic     keep;
  logic     in_range;
  logic     accept;

  assign in_range = ({1'b0, row_i} < (IDX_W+1)'(MAX_DIM)) &&
                    ({1'b0, col_i} < (IDX_W+1)'(MAX_DIM));

  always_comb begin
    case (cmd_e'(cmd_i))
      CMD_WR_A: keep = in_range;
      CMD_WR_B: keep = in_range;
      CMD_RUN:  keep = 1'b1;
      default:  keep = 1'b0;
    endcase
  end

  assign ready_o = !vld_q || !full_i;
  assign accept  = valid_i && ready_o;
  assign push_o  = vld_q;
  assign cmd_o   = cmd_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (accept) begin
      vld_q <= keep;
    end else if (!full_i) begin
      vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      cmd_q.op    <= cmd_e'(cmd_i);
      cmd_q.row   <= row_i;
      cmd_q.col   <= col_i;
      cmd_q.value <= value_i;
    end
  end

endmodule
`default_nettype wire

[src/smm_fifo.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// Command queue
// Short queue of decoded commands between the front end and the back end.
// ----------------------------------------------------------------------------
module smm_fifo import smm_pkg::*; #(
  parameter int DEPTH = SMM_FIFO_DEPTH
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic push_i,
  input  smm_cmd_t  wdata_i,
  output logic      full_o,
  output logic      valid_o,
  output smm_cmd_t  rdata_o,
  input  wire logic pop_i
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  smm_cmd_t         mem_q [DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [PTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             do_push;
  logic             do_pop;

  assign full_o  = (cnt_q == CNT_W'(DEPTH));
  assign valid_o = (cnt_q != '0);
  assign rdata_o = mem_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= wdata_i;
    end
  end

endmodule
`default_nettype wire

[src/smm_back.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// Back end
// Executes queued commands: entry writes into the A and B stores, and the
// product sequencer with its term, accumulate and resolve pipeline.
// ----------------------------------------------------------------------------
module smm_back import smm_pkg::*; #(
  parameter int MAX_DIM = SMM_MAX_DIM
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  smm_cfg_t              cfg_i,
  input  wire logic             q_valid_i,
  input  smm_cmd_t              q_cmd_i,
  output logic                  q_pop_o,
  output logic                  m_valid_o,
  input  wire logic             m_ready_i,
  output logic [IDX_W-1:0]      out_row_o,
  output logic [IDX_W-1:0]      out_col_o,
  output logic [VAL_W-1:0]      out_value_o,
  output logic                  out_last_o
);

  localparam int DEPTH  = MAX_DIM * MAX_DIM;
  localparam int ADDR_W = $clog2(DEPTH);

  // --------------------------------------------------------------------------
  // Dimensions and mode decode
  // --------------------------------------------------------------------------
  logic [DIM_W-1:0] nr, nk, nc;
  logic             is_min, is_max, is_trop;
  logic [VAL_W-1:0] ident, absorb;

  assign nr = (cfg_i.rows  > DIM_W'(MAX_DIM)) ? DIM_W'(MAX_DIM) : cfg_i.rows;
  assign nk = (cfg_i.inner > DIM_W'(MAX_DIM)) ? DIM_W'(MAX_DIM) : cfg_i.inner;
  assign nc = (cfg_i.cols  > DIM_W'(MAX_DIM)) ? DIM_W'(MAX_DIM) : cfg_i.cols;

  always_comb begin
    is_min = 1'b0;
    is_max = 1'b0;
    case (cfg_i.mode)
      MODE_MIN: is_min = 1'b1;
      MODE_MAX: is_max = 1'b1;
      default:  is_min = 1'b0;
    endcase
  end

  assign is_trop = is_min || is_max;
  assign ident   = is_min ? POS_INF : NEG_INF;
  assign absorb  = is_min ? NEG_INF : POS_INF;

  // Whole pipeline moves when the output register is free or being drained.
  logic adv;
  assign adv = !m_valid_o || m_ready_i;

  // --------------------------------------------------------------------------
  // Sequencer
  // --------------------------------------------------------------------------
  seq_e             state_q, state_d;
  logic [DIM_W-1:0] i_q, i_d, j_q, j_d, k_q, k_d;
  logic [DIM_W-1:0] nr_q, nr_d, nk_q, nk_d, nc_q, nc_d;
  logic             issue;
  logic             wr_a, wr_b;
  logic             last_k, last_j, last_i;

  assign last_k = (k_q == nk_q - 1'b1);
  assign last_j = (j_q == nc_q - 1'b1);
  assign last_i = (i_q == nr_q - 1'b1);

  always_comb begin
    state_d = state_q;
    i_d     = i_q;
    j_d     = j_q;
    k_d     = k_q;
    nr_d    = nr_q;
    nk_d    = nk_q;
    nc_d    = nc_q;
    q_pop_o = 1'b0;
    issue   = 1'b0;
    wr_a    = 1'b0;
    wr_b    = 1'b0;
    case (state_q)
      SEQ_IDLE: begin
        if (q_valid_i) begin
          q_pop_o = 1'b1;
          case (q_cmd_i.op)
            CMD_WR_A: wr_a = 1'b1;
            CMD_WR_B: wr_b = 1'b1;
            CMD_RUN: begin
              // an empty product gives no beats at all
              if (nr != '0 && nk != '0 && nc != '0) begin
                state_d = SEQ_RUN;
                i_d     = '0;
                j_d     = '0;
                k_d     = '0;
                nr_d    = nr;
                nk_d    = nk;
                nc_d    = nc;
              end
            end
            default: q_pop_o = 1'b1;
          endcase
        end
      end
      SEQ_RUN: begin
        if (adv) begin
          issue = 1'b1;
          if (!last_k) begin
            k_d = k_q + 1'b1;
          end else begin
            k_d = '0;
            if (!last_j) begin
              j_d = j_q + 1'b1;
            end else begin
              j_d = '0;
              if (!last_i) begin
                i_d = i_q + 1'b1;
              end else begin
                state_d = SEQ_IDLE;
              end
            end
          end
        end
      end
      default: state_d = SEQ_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= SEQ_IDLE;
      i_q     <= '0;
      j_q     <= '0;
      k_q     <= '0;
      nr_q    <= '0;
      nk_q    <= '0;
      nc_q    <= '0;
    end else begin
      state_q <= state_d;
      i_q     <= i_d;
      j_q     <= j_d;
      k_q     <= k_d;
      nr_q    <= nr_d;
      nk_q    <= nk_d;
      nc_q    <= nc_d;
    end
  end

  // --------------------------------------------------------------------------
  // Stores
  // --------------------------------------------------------------------------
  logic [ADDR_W-1:0] waddr, raddr_a, raddr_b;
  logic [VAL_W-1:0]  a_data, b_data;

  assign waddr   = ADDR_W'(q_cmd_i.row * MAX_DIM + q_cmd_i.col);
  assign raddr_a = ADDR_W'(i_q * MAX_DIM + k_q);
  assign raddr_b = ADDR_W'(k_q * MAX_DIM + j_q);

  smm_ram #(
    .WIDTH (VAL_W),
    .DEPTH (DEPTH)
  ) u_a_store (
    .clk_i   (clk_i),
    .we_i    (wr_a),
    .waddr_i (waddr),
    .wdata_i (q_cmd_i.value),
    .re_i    (issue),
    .raddr_i (raddr_a),
    .rdata_o (a_data)
  );

  smm_ram #(
    .WIDTH (VAL_W),
    .DEPTH (DEPTH)
  ) u_b_store (
    .clk_i   (clk_i),
    .we_i    (wr_b),
    .waddr_i (waddr),
    .wdata_i (q_cmd_i.value),
    .re_i    (issue),
    .raddr_i (raddr_b),
    .rdata_o (b_data)
  );

  // --------------------------------------------------------------------------
  // Stage 1: read data arrives
  // --------------------------------------------------------------------------
  logic             v1_q, first1_q, lastk1_q, fin1_q;
  logic [IDX_W-1:0] row1_q, col1_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
    end else if (adv) begin
      v1_q <= issue;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      first1_q <= (k_q == '0);
      lastk1_q <= last_k;
      fin1_q   <= last_i && last_j;
      row1_q   <= i_q[IDX_W-1:0];
      col1_q   <= j_q[IDX_W-1:0];
    end
  end

  // --------------------------------------------------------------------------
  // Stage 2: one term
  // --------------------------------------------------------------------------
  logic                    a_inf, b_inf, sop_skip, any_inf;
  logic signed [PROD_W-1:0] prod;
  logic [VAL_W-1:0]        trop_t;
  logic                    trop_keep;

  assign a_inf    = (a_data == POS_INF) || (a_data == NEG_INF);
  assign b_inf    = (b_data == POS_INF) || (b_data == NEG_INF);
  assign sop_skip = (a_data == '0) || (b_data == '0);
  assign any_inf  = a_inf || b_inf;
  assign prod     = $signed(a_data) * $signed(b_data);

  assign trop_keep = !((a_data == ident) || (b_data == ident));
  assign trop_t    = ((a_data == absorb) || (b_data == absorb)) ? absorb :
                     sat_sum({a_data[VAL_W-1], a_data} + {b_data[VAL_W-1], b_data});

  logic              v2_q, first2_q, lastk2_q, fin2_q;
  logic [IDX_W-1:0]  row2_q, col2_q;
  logic [PROD_W-1:0] prod2_q;
  logic              pinf2_q, ninf2_q, tkeep2_q;
  logic [VAL_W-1:0]  trop2_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v2_q <= 1'b0;
    end else if (adv) begin
      v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      first2_q <= first1_q;
      lastk2_q <= lastk1_q;
      fin2_q   <= fin1_q;
      row2_q   <= row1_q;
      col2_q   <= col1_q;
      prod2_q  <= (sop_skip || any_inf) ? '0 : prod;
      pinf2_q  <= !sop_skip && any_inf && (a_data[VAL_W-1] == b_data[VAL_W-1]);
      ninf2_q  <= !sop_skip && any_inf && (a_data[VAL_W-1] != b_data[VAL_W-1]);
      trop2_q  <= trop_t;
      tkeep2_q <= trop_keep;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 3: accumulate
  // --------------------------------------------------------------------------
  logic [ACC_W-1:0] acc_sum_q, acc_sum_d, sum_base;
  logic             acc_pos_q, acc_pos_d, acc_neg_q, acc_neg_d;
  logic [VAL_W-1:0] acc_trop_q, acc_trop_d, trop_base;
  logic             better;

  assign sum_base  = first2_q ? '0 : acc_sum_q;
  assign trop_base = first2_q ? ident : acc_trop_q;
  assign better    = is_min ? ($signed(trop2_q) < $signed(trop_base)) :
                              ($signed(trop2_q) > $signed(trop_base));

  always_comb begin
    acc_sum_d  = sum_base + {{(ACC_W-PROD_W){prod2_q[PROD_W-1]}}, prod2_q};
    acc_pos_d  = (!first2_q && acc_pos_q) || pinf2_q;
    acc_neg_d  = (!first2_q && acc_neg_q) || ninf2_q;
    acc_trop_d = (tkeep2_q && better) ? trop2_q : trop_base;
  end

  logic             v3_q, fin3_q;
  logic [IDX_W-1:0] row3_q, col3_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v3_q <= 1'b0;
    end else if (adv) begin
      v3_q <= v2_q && lastk2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      fin3_q <= fin2_q;
      row3_q <= row2_q;
      col3_q <= col2_q;
      if (v2_q) begin
        acc_sum_q  <= acc_sum_d;
        acc_pos_q  <= acc_pos_d;
        acc_neg_q  <= acc_neg_d;
        acc_trop_q <= acc_trop_d;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Resolve and output register
  // --------------------------------------------------------------------------
  logic [VAL_W-1:0] result;

  always_comb begin
    if (is_trop) begin
      result = acc_trop_q;
    end else if (acc_pos_q && acc_neg_q) begin
      result = '0;
    end else if (acc_pos_q) begin
      result = POS_INF;
    end else if (acc_neg_q) begin
      result = NEG_INF;
    end else begin
      result = sat_acc(acc_sum_q);
    end
  end

  logic             out_vld_q;
  logic [IDX_W-1:0] out_row_q, out_col_q;
  logic [VAL_W-1:0] out_val_q;
  logic             out_last_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (adv) begin
      out_vld_q <= v3_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv && v3_q) begin
      out_row_q  <= row3_q;
      out_col_q  <= col3_q;
      out_val_q  <= result;
      out_last_q <= fin3_q;
    end
  end

  assign m_valid_o   = out_vld_q;
  assign out_row_o   = out_row_q;
  assign out_col_o   = out_col_q;
  assign out_value_o = out_val_q;
  assign out_last_o  = out_last_q;

endmodule
`default_nettype wire

[src/smm_checker.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// Semiring matrix multiply checker
// Port-level assertions, bound to the top level.
// ----------------------------------------------------------------------------
module smm_checker import smm_pkg::*; (
  input wire logic               clk_i,
  input wire logic               rst_ni,
  input wire logic               psel,
  input wire logic               penable,
  input wire logic               pwrite,
  input wire logic [3:0]         paddr,
  input wire logic [31:0]        pwdata,
  input wire logic [31:0]        prdata,
  input wire logic               pready,
  input wire logic               s_axis_tvalid,
  input wire logic               s_axis_tready,
  input wire logic [TDATA_W-1:0] s_axis_tdata,
  input wire logic [1:0]         s_axis_tuser,
  input wire logic               m_axis_tvalid,
  input wire logic               m_axis_tready,
  input wire logic [TDATA_W-1:0] m_axis_tdata,
  input wire logic               m_axis_tlast
);

  // hold a stalled result beat
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast))
    else $error("result beat changed while stalled");

  // hold an offered input beat until it is taken
  a_in_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && !s_axis_tready |=>
      s_axis_tvalid && $stable(s_axis_tdata) && $stable(s_axis_tuser))
    else $error("input beat changed while stalled");

  // input ready drops only after the front took a beat
  a_ready_drop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(s_axis_tready) |-> $past(s_axis_tvalid))
    else $error("input ready dropped without an accepted beat");

  // a written register reads back its masked value
  a_readback: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (psel && penable && pwrite && pready) ##1 (psel && !pwrite && paddr == $past(paddr))
      |-> prdata == ((paddr[3:2] == REG_MODE) ? {30'd0, $past(pwdata[1:0])}
                                              : {28'd0, $past(pwdata[3:0])}))
    else $error("configuration readback mismatch");

endmodule

bind semiring_matrix_multiply smm_checker u_smm_checker (.*);
`default_nettype wire
